// File: rtl/rrcd_pkg.sv
// shared types, codes and constants of the round-robin capacity dispatcher
package rrcd_pkg;

  // default worker count and load counter width
  localparam int unsigned WORKERS_DEFAULT = 8;
  localparam int unsigned LOAD_W          = 8;
  localparam int unsigned TAG_W           = 16;
  localparam int unsigned WID_W           = 3;
  localparam int unsigned CAP_W           = 8;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd64;

  // request operation
  typedef enum logic [0:0] {
    OP_ASSIGN  = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_ASSIGNED    = 2'd0,
    ST_REJECTED    = 2'd1,
    ST_RELEASED    = 2'd2,
    ST_REL_IGNORED = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_RELEASE
  } fsm_e;

  // input item
  typedef struct packed {
    op_e               op;
    logic [TAG_W-1:0]  client_tag;
    logic [WID_W-1:0]  target_worker;
  } req_t;

  // result item
  typedef struct packed {
    status_e           status;
    logic [WID_W-1:0]  chosen_worker;
    logic [TAG_W-1:0]  client_tag_out;
  } rsp_t;

endpackage

// File: rtl/rrcd_load_mem.sv
// worker load memory with per-entry valid bits and a registered read
module rrcd_load_mem #(
  parameter int unsigned WORKERS = rrcd_pkg::WORKERS_DEFAULT,
  parameter int unsigned IDX_W   = $clog2(WORKERS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [IDX_W-1:0]          rd_addr_i,
  output logic [rrcd_pkg::LOAD_W-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_addr_i,
  input  logic [rrcd_pkg::LOAD_W-1:0] wr_data_i
);
  import rrcd_pkg::*;

  logic [LOAD_W-1:0]  mem_q [WORKERS];
  logic [WORKERS-1:0] vld_q;
  logic [LOAD_W-1:0]  rdata_q;
  logic               rvld_q;

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem_q[rd_addr_i];
  end

  // valid bits: an entry never written reads as zero load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rvld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/round_robin_capacity_dispatcher_unit.sv
// round-robin dispatcher top level: sequencer around the worker load memory
//
//  port group     dir  width            meaning
//  start/req_i    in   1 + req_t        request transfer, taken when start & !busy
//  busy           out  1                request channel cannot take a transfer
//  result_valid_o out  1                one-cycle strobe for the result transfer
//  rsp_o          out  rsp_t            result payload, valid with the strobe
//  cfg_we_i/wdata in   1 + 8            capacity register write
//
// An assign walks the load memory from the round-robin pointer, one worker per
// cycle, and visits at most WORKERS workers; a release handles its one target.
// The result strobe is registered and comes in the cycle after the last scan or release cycle.
// busy drops during the strobe cycle, so a new request may overlap it.
// Reset clears all loads (valid bits), the pointer and sets capacity to 64.
// The receiver cannot stall: each result is presented for exactly one cycle.
module round_robin_capacity_dispatcher_unit #(
  parameter int unsigned WORKERS = rrcd_pkg::WORKERS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  rrcd_pkg::req_t             req_i,
  output logic                       result_valid_o,
  output rrcd_pkg::rsp_t             rsp_o,
  input  logic                       cfg_we_i,
  input  logic [rrcd_pkg::CAP_W-1:0] cfg_wdata_i
);
  import rrcd_pkg::*;

  localparam int unsigned IDX_W = $clog2(WORKERS);
  localparam int unsigned EXT_W = ((IDX_W > WID_W) ? IDX_W : WID_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORKERS - 1);

  // registers
  fsm_e              state_q, state_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [WID_W-1:0]  tgt_q, tgt_d;
  logic [CAP_W-1:0]  cap_q;
  rsp_t              rsp_q, rsp_d;
  logic              strobe_q, strobe_d;

  // memory port
  logic [IDX_W-1:0]  rd_addr;
  logic [LOAD_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [LOAD_W-1:0] wr_data;

  // helpers
  logic              accept;
  logic [EXT_W-1:0]  req_tgt_ext;
  logic [EXT_W-1:0]  tgt_ext;
  logic [EXT_W-1:0]  idx_ext;
  logic              req_tgt_ok;
  logic              tgt_ok;
  logic              hit;
  logic              scan_last;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign busy        = (state_q != FSM_IDLE);
  assign accept      = start && !busy;
  assign req_tgt_ext = EXT_W'(req_i.target_worker);
  assign tgt_ext     = EXT_W'(tgt_q);
  assign idx_ext     = EXT_W'(idx_q);
  assign req_tgt_ok  = (req_tgt_ext < EXT_W'(WORKERS));
  assign tgt_ok      = (tgt_ext < EXT_W'(WORKERS));
  assign hit         = (rd_data < cap_q);
  assign scan_last   = (cnt_q == LAST_IDX);

  // load memory
  rrcd_load_mem #(
    .WORKERS (WORKERS),
    .IDX_W   (IDX_W)
  ) u_load_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = (req_i.op == OP_RELEASE) ? FSM_RELEASE : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (hit || scan_last) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_RELEASE: state_d = FSM_IDLE;
      default:     state_d = FSM_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    tag_d    = tag_q;
    tgt_d    = tgt_q;
    rsp_d    = rsp_q;
    strobe_d = 1'b0;
    rd_addr  = ptr_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q;
    wr_data  = rd_data + 1'b1;
    case (state_q)
      FSM_IDLE: begin
        // read the first candidate or the release target
        if (start && req_i.op == OP_RELEASE) begin
          rd_addr = req_tgt_ok ? req_tgt_ext[IDX_W-1:0] : '0;
        end
        if (accept) begin
          idx_d = ptr_q;
          cnt_d = '0;
          tag_d = req_i.client_tag;
          tgt_d = req_i.target_worker;
        end
      end
      FSM_SCAN: begin
        // check one worker, prefetch the following one
        rd_addr = wrap_idx(idx_q);
        rsp_d.client_tag_out = tag_q;
        if (hit) begin
          wr_en                = 1'b1;
          ptr_d                = wrap_idx(idx_q);
          rsp_d.status         = ST_ASSIGNED;
          rsp_d.chosen_worker  = idx_ext[WID_W-1:0];
          strobe_d             = 1'b1;
        end else if (scan_last) begin
          ptr_d                = wrap_idx(ptr_q);
          rsp_d.status         = ST_REJECTED;
          rsp_d.chosen_worker  = '0;
          strobe_d             = 1'b1;
        end else begin
          idx_d = wrap_idx(idx_q);
          cnt_d = cnt_q + 1'b1;
        end
      end
      FSM_RELEASE: begin
        // decrement unless out of range or already empty
        wr_addr              = tgt_ext[IDX_W-1:0];
        wr_data              = rd_data - 1'b1;
        rsp_d.client_tag_out = tag_q;
        rsp_d.chosen_worker  = tgt_q;
        strobe_d             = 1'b1;
        if (tgt_ok && rd_data != '0) begin
          wr_en        = 1'b1;
          rsp_d.status = ST_RELEASED;
        end else begin
          rsp_d.status = ST_REL_IGNORED;
        end
      end
      default: begin
        rd_addr = ptr_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      ptr_q    <= '0;
      cap_q    <= CAPACITY_RESET;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    tag_q <= tag_d;
    tgt_q <= tgt_d;
    rsp_q <= rsp_d;
  end

  assign result_valid_o = strobe_q;
  assign rsp_o          = rsp_q;

  // pointer always names an existing worker
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LAST_IDX)
    else $error("round-robin pointer beyond last worker");

  // the scan never visits a worker twice
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_SCAN |-> cnt_q <= LAST_IDX)
    else $error("scan count beyond worker count");

  // loads change only while a request is in flight
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q != FSM_IDLE)
    else $error("load write while idle");

  // a release transfer yields its result through the release state and the result register
  a_release_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.op == OP_RELEASE |-> ##2 result_valid_o)
    else $error("release result missing");

  // results never come back to back
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

// File: tb/sv/round_robin_capacity_dispatcher_unit_tb.sv
// self-checking testbench for the round-robin capacity dispatcher
`timescale 1ns / 1ps

module round_robin_capacity_dispatcher_unit_tb;
  import rrcd_pkg::*;

  localparam int unsigned W          = WORKERS_DEFAULT;
  localparam int unsigned SETTLE     = W + 4;
  localparam int unsigned CYCLE_CAP  = 500000;
  localparam int unsigned PRINT_CAP  = 40;

  // one entry of the command stream: a request or a capacity write
  typedef struct {
    bit               is_cap;
    logic [CAP_W-1:0] cap_val;
    req_t             rq;
    int               gap;
  } dispatch_cmd_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             result_valid_o;
  rsp_t             rsp_o;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  dispatch_cmd_t cmd_queue [$];
  rsp_t          due_results [$];

  // shadow of the dispatcher state
  logic [LOAD_W-1:0] load_model [W];
  int unsigned       rr_ptr;
  logic [CAP_W-1:0]  cap_model;

  int unsigned settle_cnt;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  round_robin_capacity_dispatcher_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // outcome of one request against the shadow state; updates that state
  function automatic rsp_t next_dispatch(req_t rq);
    rsp_t        r;
    int unsigned idx;
    bit          found;
    r.client_tag_out = rq.client_tag;
    r.chosen_worker  = '0;
    if (rq.op == OP_ASSIGN) begin
      idx   = rr_ptr;
      found = 1'b0;
      for (int unsigned k = 0; k < W; k++) begin
        if (!found) begin
          if (load_model[idx] < cap_model) found = 1'b1;
          else idx = (idx + 1) % W;
        end
      end
      if (found) begin
        load_model[idx] = load_model[idx] + 1'b1;
        r.chosen_worker = idx[WID_W-1:0];
        rr_ptr          = (idx + 1) % W;
        r.status        = ST_ASSIGNED;
      end else begin
        rr_ptr   = (rr_ptr + 1) % W;
        r.status = ST_REJECTED;
      end
    end else begin
      r.chosen_worker = rq.target_worker;
      if (rq.target_worker < W && load_model[rq.target_worker] != '0) begin
        load_model[rq.target_worker] = load_model[rq.target_worker] - 1'b1;
        r.status = ST_RELEASED;
      end else begin
        r.status = ST_REL_IGNORED;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic add_req(op_e op, logic [TAG_W-1:0] tag, logic [WID_W-1:0] tgt, int gap);
    dispatch_cmd_t c;
    c.is_cap           = 1'b0;
    c.cap_val          = '0;
    c.rq.op            = op;
    c.rq.client_tag    = tag;
    c.rq.target_worker = tgt;
    c.gap              = gap;
    cmd_queue.push_back(c);
  endtask

  task automatic add_cap(logic [CAP_W-1:0] val);
    dispatch_cmd_t c;
    c.is_cap  = 1'b1;
    c.cap_val = val;
    c.rq      = '0;
    c.gap     = 0;
    cmd_queue.push_back(c);
  endtask

  // mostly short gaps, a few long ones, none at all in a burst
  function automatic int pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // random phase at one capacity setting
  task automatic add_phase(logic [CAP_W-1:0] cap, int n, int assign_pct, bit burst);
    op_e op;
    add_cap(cap);
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < assign_pct) ? OP_ASSIGN : OP_RELEASE;
      add_req(op, TAG_W'($urandom), WID_W'($urandom_range(0, 7)), pick_gap(burst));
    end
  endtask

  // driver: presents requests and capacity writes from the command queue
  always @(posedge clk_i) begin : drive_proc
    logic             take;
    logic             nx_start;
    req_t             nx_req;
    logic             nx_we;
    logic [CAP_W-1:0] nx_wd;
    take     = start && !busy;
    nx_start = start;
    nx_req   = req_i;
    nx_we    = 1'b0;
    nx_wd    = cfg_wdata_i;
    if (!rst_ni) begin
      nx_start   = 1'b0;
      settle_cnt = 0;
    end else begin
      if (take) due_results.push_back(next_dispatch(req_i));
      // count quiet cycles before a capacity write
      if (take || start || due_results.size() != 0) settle_cnt = 0;
      else settle_cnt++;
      if (!start || take) begin
        nx_start = 1'b0;
        if (cmd_queue.size() != 0) begin
          if (cmd_queue[0].is_cap) begin
            if (settle_cnt >= SETTLE) begin
              nx_we      = 1'b1;
              nx_wd      = cmd_queue[0].cap_val;
              cap_model  = cmd_queue[0].cap_val;
              settle_cnt = 0;
              void'(cmd_queue.pop_front());
            end
          end else if (cmd_queue[0].gap > 0) begin
            cmd_queue[0].gap--;
          end else begin
            nx_start = 1'b1;
            nx_req   = cmd_queue[0].rq;
            void'(cmd_queue.pop_front());
          end
        end
      end
    end
    start       <= nx_start;
    req_i       <= nx_req;
    cfg_we_i    <= nx_we;
    cfg_wdata_i <= nx_wd;
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin : check_proc
    rsp_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", rsp_o));
      end else begin
        exp_r = due_results.pop_front();
        if (rsp_o.status !== exp_r.status)
          report_mismatch($sformatf("status got %0d expected %0d",
                                    rsp_o.status, exp_r.status));
        if (rsp_o.chosen_worker !== exp_r.chosen_worker)
          report_mismatch($sformatf("chosen_worker got %0d expected %0d",
                                    rsp_o.chosen_worker, exp_r.chosen_worker));
        if (rsp_o.client_tag_out !== exp_r.client_tag_out)
          report_mismatch($sformatf("client_tag_out got %h expected %h",
                                    rsp_o.client_tag_out, exp_r.client_tag_out));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    settle_cnt   = 0;
    rr_ptr       = 0;
    cap_model    = CAPACITY_RESET;
    for (int i = 0; i < W; i++) load_model[i] = '0;

    // releases on empty and loaded workers, tag extremes, at reset capacity
    add_req(OP_RELEASE, 16'h0000, 3'd0, 0);
    add_req(OP_RELEASE, 16'hffff, 3'd7, 1);
    add_req(OP_ASSIGN,  16'h0000, 3'd7, 0);
    add_req(OP_ASSIGN,  16'hffff, 3'd0, 0);
    add_req(OP_RELEASE, 16'h5a5a, 3'd1, 2);
    add_req(OP_RELEASE, 16'ha5a5, 3'd1, 0);
    // capacity one: fill every worker, then all-full rejects
    add_cap(8'd1);
    for (int i = 0; i < 9; i++) add_req(OP_ASSIGN, TAG_W'(16'h1000 + i), 3'd0, i % 2);
    add_req(OP_ASSIGN,  16'h2000, 3'd0, 0);
    add_req(OP_RELEASE, 16'h2001, 3'd3, 0);
    add_req(OP_ASSIGN,  16'h2002, 3'd0, 3);
    // capacity zero rejects every assign
    add_cap(8'd0);
    add_req(OP_ASSIGN,  16'h3000, 3'd0, 0);
    add_req(OP_RELEASE, 16'h3001, 3'd0, 0);
    add_req(OP_ASSIGN,  16'h3002, 3'd0, 1);
    // top capacity
    add_cap(8'd255);
    add_req(OP_ASSIGN,  16'h4000, 3'd0, 0);
    add_req(OP_RELEASE, 16'h4001, 3'd6, 0);

    // random phases; some capacities drop below loads left from before
    add_phase(8'd2,   150, 70, 1'b0);
    add_phase(8'd5,   150, 60, 1'b1);
    add_phase(8'd1,   100, 50, 1'b0);
    add_phase(8'd255, 120, 45, 1'b0);
    add_phase(8'd3,   150, 40, 1'b0);
    add_phase(8'd0,    30, 50, 1'b0);
    add_phase(8'd128, 100, 55, 1'b1);
    add_phase(8'd4,   150, 60, 1'b0);
    add_phase(8'd2,   100, 50, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || due_results.size() != 0 || start) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
rtl/rrcd_pkg.sv
rtl/rrcd_load_mem.sv
rtl/round_robin_capacity_dispatcher_unit.sv
tb/sv/round_robin_capacity_dispatcher_unit_tb.sv
